/* rtl/pacd_pkg.sv */
// Package for the PWM angle capture decoder: constants, payload and control types.
`default_nettype none
package pacd_pkg;

  localparam int unsigned FULL_TURN  = 3600;
  localparam int unsigned ANGLE_W    = 12;
  localparam int unsigned STAMP_W    = 16;

  localparam logic OP_ARM     = 1'b0;
  localparam logic OP_CAPTURE = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [STAMP_W-1:0] capture_time;
    logic               pin_low;
    logic               capture_pending;
  } pacd_in_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle_tenth_degree;
    logic               short_pulse;
    logic               period_error;
  } pacd_out_t;

  // Position within one measurement sequence.
  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_END   = 2'd1,
    PH_FALL  = 2'd2
  } pacd_phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_WRITE
  } pacd_state_e;

  typedef struct packed {
    logic accept;
    logic mul;
    logic div_step;
    logic fin;
    logic load_out;
  } pacd_cmd_t;

  typedef struct packed {
    logic need_short;
    logic need_div;
    logic div_last;
    logic out_free;
  } pacd_sts_t;

endpackage
`default_nettype wire

/* rtl/pacd_ctrl.sv */
// Controller state machine that sequences accept, multiply, divide and output load.
`default_nettype none
module pacd_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire pacd_pkg::pacd_sts_t sts_i,
  output      pacd_pkg::pacd_cmd_t cmd_o
);

  pacd_pkg::pacd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pacd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      pacd_pkg::ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          if (sts_i.need_short) begin
            state_d = pacd_pkg::ST_WRITE;
          end else if (sts_i.need_div) begin
            state_d = pacd_pkg::ST_MUL;
          end
        end
      end
      pacd_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = pacd_pkg::ST_DIV;
      end
      pacd_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = pacd_pkg::ST_FIN;
        end
      end
      pacd_pkg::ST_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = pacd_pkg::ST_WRITE;
      end
      pacd_pkg::ST_WRITE: begin
        // hold until the output register can take the beat
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = pacd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pacd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/pacd_dp.sv */
// Datapath: sequence state, stamps, multiplier, restoring divider with modular quotient.
`default_nettype none
module pacd_dp #(
  parameter int unsigned FullTurn = pacd_pkg::FULL_TURN
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire pacd_pkg::pacd_in_t           in_data_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [pacd_pkg::ANGLE_W-1:0] cfg_wdata_i,
  input  wire pacd_pkg::pacd_cmd_t          cmd_i,
  output      pacd_pkg::pacd_sts_t          sts_o,
  output      logic                         out_valid_o,
  input  wire logic                         out_stall_i,
  output      pacd_pkg::pacd_out_t          out_data_o
);

  localparam int unsigned StampW = pacd_pkg::STAMP_W;
  localparam int unsigned AngleW = pacd_pkg::ANGLE_W;
  localparam int unsigned ModW   = $clog2(FullTurn + 1);
  localparam int unsigned ProdW  = StampW + ModW;
  localparam int unsigned CntW   = $clog2(ProdW);
  localparam int unsigned OffW   = (ModW > AngleW) ? ModW : AngleW;

  // sequence state
  pacd_pkg::pacd_phase_e phase_q;
  logic                  armed_q;
  logic [StampW-1:0]     start_q;
  logic [StampW-1:0]     end_q;
  logic [AngleW-1:0]     cfg_q;

  // arithmetic
  logic [StampW-1:0]     high_q;
  logic [StampW-1:0]     period_q;
  logic                  short_q;
  logic [ProdW-1:0]      dvd_q;
  logic [StampW-1:0]     rem_q;
  logic [ModW-1:0]       qmod_q;
  logic [ModW-1:0]       angle_q;
  logic [CntW-1:0]       cnt_q;

  logic                  out_valid_q;
  pacd_pkg::pacd_out_t   out_q;

  logic                  is_capture;
  logic [OffW-1:0]       off_ext;
  logic [OffW-1:0]       full_ext;
  logic [OffW-1:0]       off_sat;
  logic [ModW-1:0]       offset_term;
  logic [StampW:0]       trial;
  logic                  trial_ge;
  logic [ModW:0]         qmod_dbl;
  logic [ModW-1:0]       qmod_next;
  logic [ModW:0]         fin_sum;
  logic [ModW-1:0]       fin_red;

  assign is_capture = (in_data_i.opcode == pacd_pkg::OP_CAPTURE) && armed_q;

  assign sts_o.need_short = is_capture && (phase_q == pacd_pkg::PH_END) &&
                            in_data_i.pin_low && !in_data_i.capture_pending;
  assign sts_o.need_div   = is_capture && (phase_q == pacd_pkg::PH_FALL);
  assign sts_o.div_last   = (cnt_q == '0);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  // offset saturates at a full turn
  always_comb begin
    off_ext     = OffW'(cfg_q);
    full_ext    = OffW'(FullTurn);
    off_sat     = (off_ext > full_ext) ? full_ext : off_ext;
    offset_term = ModW'(full_ext - off_sat);
  end

  // one restoring step; the quotient is kept only modulo a full turn
  always_comb begin
    trial     = {rem_q, dvd_q[ProdW-1]};
    trial_ge  = (trial >= {1'b0, period_q});
    qmod_dbl  = {qmod_q, trial_ge};
    qmod_next = (qmod_dbl >= (ModW+1)'(FullTurn)) ?
                ModW'(qmod_dbl - (ModW+1)'(FullTurn)) : ModW'(qmod_dbl);
    fin_sum   = (ModW+1)'(qmod_q) + (ModW+1)'(offset_term);
    fin_red   = (fin_sum >= (ModW+1)'(FullTurn)) ?
                ModW'(fin_sum - (ModW+1)'(FullTurn)) : ModW'(fin_sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pacd_pkg::PH_START;
      armed_q <= 1'b0;
      start_q <= '0;
      end_q   <= StampW'(1);
      cfg_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        if (in_data_i.opcode == pacd_pkg::OP_ARM) begin
          phase_q <= pacd_pkg::PH_START;
          armed_q <= 1'b1;
        end else if (armed_q) begin
          unique case (phase_q)
            pacd_pkg::PH_START: begin
              start_q <= in_data_i.capture_time;
              phase_q <= pacd_pkg::PH_END;
            end
            pacd_pkg::PH_END: begin
              end_q <= in_data_i.capture_time;
              if (sts_o.need_short) begin
                phase_q <= pacd_pkg::PH_START;
                armed_q <= 1'b0;
              end else begin
                phase_q <= pacd_pkg::PH_FALL;
              end
            end
            pacd_pkg::PH_FALL: begin
              phase_q <= pacd_pkg::PH_START;
              armed_q <= 1'b0;
            end
            default: begin
              phase_q <= phase_q;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      high_q   <= in_data_i.capture_time - end_q;
      period_q <= end_q - start_q;
      short_q  <= sts_o.need_short;
    end
    if (cmd_i.mul) begin
      dvd_q  <= ProdW'(high_q) * ProdW'(FullTurn);
      rem_q  <= '0;
      qmod_q <= '0;
      cnt_q  <= CntW'(ProdW - 1);
    end
    if (cmd_i.div_step) begin
      dvd_q  <= {dvd_q[ProdW-2:0], 1'b0};
      rem_q  <= trial_ge ? StampW'(trial - {1'b0, period_q}) : trial[StampW-1:0];
      qmod_q <= qmod_next;
      cnt_q  <= cnt_q - CntW'(1);
    end
    if (cmd_i.fin) begin
      angle_q <= fin_red;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      if (short_q) begin
        out_q.angle_tenth_degree <= AngleW'(offset_term);
        out_q.short_pulse        <= 1'b1;
        out_q.period_error       <= 1'b0;
      end else if (period_q == '0) begin
        out_q.angle_tenth_degree <= '0;
        out_q.short_pulse        <= 1'b0;
        out_q.period_error       <= 1'b1;
      end else begin
        out_q.angle_tenth_degree <= AngleW'(angle_q);
        out_q.short_pulse        <= 1'b0;
        out_q.period_error       <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

/* rtl/pwm_angle_capture_decoder.sv */
// Top level of the PWM angle capture decoder: controller plus datapath.
`default_nettype none
// Decodes a PWM angle sensor from timer capture beats. An arm beat restarts the
// sequence; the next two captures mark the period start and end, the third the
// falling edge, and a result beat carries the angle in tenths of a degree. Arm
// beats and the first two captures are taken directly in the idle state; a short
// pulse result goes straight to the output load. The falling-edge capture runs
// through these steps in order: form the differences, multiply, one restoring
// divider step per quotient bit, add the offset, and load the output register.
// The input stalls while an item is in work; the output register holds a result
// while the next item is taken, and the block waits only if that register still
// holds a stalled result when a new result is ready. angle_offset is written
// through cfg_we_i/cfg_wdata_i; the user must do so only while the block is idle,
// as the block itself does not enforce this.
module pwm_angle_capture_decoder #(
  parameter int unsigned FullTurn = pacd_pkg::FULL_TURN
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [pacd_pkg::ANGLE_W-1:0] cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output      logic                         in_stall_o,
  input  wire pacd_pkg::pacd_in_t           in_data_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_stall_i,
  output      pacd_pkg::pacd_out_t          out_data_o
);

  pacd_pkg::pacd_cmd_t cmd;
  pacd_pkg::pacd_sts_t sts;

  pacd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pacd_dp #(
    .FullTurn (FullTurn)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

/* rtl/pacd_checker.sv */
// Port-level assertions for the PWM angle capture decoder and their bind.
`default_nettype none
module pacd_checker #(
  parameter int unsigned FullTurn = pacd_pkg::FULL_TURN
) (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire pacd_pkg::pacd_out_t out_data_o
);

  // a stalled result beat stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.short_pulse && out_data_o.period_error))
    else $error("short pulse and period error both set");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.period_error |-> out_data_o.angle_tenth_degree == '0)
    else $error("period error with nonzero angle");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.short_pulse |->
      int'(out_data_o.angle_tenth_degree) < int'(FullTurn))
    else $error("reduced angle not below a full turn");

endmodule

bind pwm_angle_capture_decoder pacd_checker #(
  .FullTurn (FullTurn)
) u_pacd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
